@@ hdl/sha256_message_hasher_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Implication checked on every edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

@@ hdl/sha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash words and shared types.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int LengthPos  = 56;
	localparam int QueueDepth = 4;
	localparam logic [7:0] PadByte = 8'h80;

	// One queued request from the front part to the back part.
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       last;
	} req_t;

	// Back part sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k [64];
		k = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
		return k[t];
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ hdl/sha_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready/valid channel interfaces
// Input byte channel and digest word channel.
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;
	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hdl/sha_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 front part
// Accepts requests, drops empty ones and queues the rest for the back part.
// ----------------------------------------------------------------------------
module sha_front #(
	parameter int Depth = sha_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	sha_in_if.sink         in_ch,
	output sha_pkg::req_t  req,
	output logic           req_valid,
	input  logic           req_pop
);
	localparam int AW = $clog2(Depth);

	sha_pkg::req_t    mem_q [Depth];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             push, keep;

	// Requests with neither a byte nor an end mark change nothing.
	assign keep = in_ch.byte_present | in_ch.end_of_message;
	assign in_ch.ready = (cnt_q != (AW+1)'(Depth));
	assign push = in_ch.valid & in_ch.ready & keep;
	assign req_valid = (cnt_q != '0);
	assign req = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{has_byte: in_ch.byte_present, data: in_ch.data_byte,
				last: in_ch.end_of_message};
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (req_pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(req_pop);
		end
	end
endmodule

@@ hdl/sha_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 back part
// Buffers 64-byte blocks, runs one round per cycle, pads and emits digests.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sha_pkg::req_t  req,
	input  logic           req_valid,
	output logic           req_pop,
	sha_out_if.source      out_ch
);
	sha_pkg::state_t state_q, state_d;

	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  round_q;
	logic [2:0]  widx_q;
	logic        final_q;    // block being compressed ends the message
	logic        pad_done_q; // 0x80 already written into an earlier block
	logic        end_pend_q; // end mark arrived with the block-filling byte
	logic        out_v_q;
	logic [31:0] out_w_q;
	logic        take, blk_full, pad_last;
	logic [31:0] s0, s1, wn, t1, t2;

	// Byte into the block buffer, big-endian within each word.
	function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
		input logic [7:0] b);
		logic [31:0] r;
		r = w;
		r[8*(3-p) +: 8] = b;
		return r;
	endfunction

	assign take = (state_q == sha_pkg::ST_IDLE) & req_valid;
	assign req_pop = take;
	assign blk_full = req.has_byte & (fill_q == 6'd63);
	// Padding ends in this block when 0x80 lands below the length field or was already written.
	assign pad_last = pad_done_q | (fill_q < 6'(sha_pkg::LengthPos));

	// Message schedule and round logic.
	assign s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = hh_q + (sha_pkg::rotr(e_q, 6) ^ sha_pkg::rotr(e_q, 11) ^ sha_pkg::rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + sha_pkg::round_k(round_q) + w_q[0];
	assign t2 = (sha_pkg::rotr(a_q, 2) ^ sha_pkg::rotr(a_q, 13) ^ sha_pkg::rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				if (take) begin
					if (blk_full) state_d = sha_pkg::ST_ROUND;
					else if (req.last) state_d = sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_PAD:   state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_ROUND: if (round_q == 6'd63) state_d = sha_pkg::ST_ADD;
			sha_pkg::ST_ADD: begin
				if (final_q) state_d = sha_pkg::ST_EMIT;
				else if (pad_done_q | end_pend_q | (fill_q != 6'd0)) state_d = sha_pkg::ST_PAD;
				else state_d = sha_pkg::ST_IDLE;
			end
			sha_pkg::ST_EMIT: begin
				if (out_ch.ready & out_v_q & (widx_q == 3'd7)) state_d = sha_pkg::ST_IDLE;
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sha_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Outputs.
	always_comb begin
		out_ch.valid       = out_v_q;
		out_ch.digest_word = out_w_q;
		out_ch.word_index  = widx_q;
		out_ch.last_word   = (widx_q == 3'd7);
	end

	// Datapath and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
			fill_q     <= '0;
			bits_q     <= '0;
			round_q    <= '0;
			widx_q     <= '0;
			final_q    <= 1'b0;
			pad_done_q <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			case (state_q)
				sha_pkg::ST_IDLE: begin
					if (take) begin
						if (req.has_byte) begin
							w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0], req.data);
							fill_q <= fill_q + 1'b1;
							bits_q <= bits_q + 64'd8;
						end
						final_q <= 1'b0;
						// A full block with an end mark pads after compressing.
						pad_done_q <= 1'b0;
						if (blk_full) begin
							final_q <= 1'b0;
							{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
							{e_q, f_q, g_q, hh_q} <= {h_q[4], h_q[5], h_q[6], h_q[7]};
							round_q <= '0;
						end
					end
				end
				sha_pkg::ST_PAD: begin
					// Write 0x80 (unless already written), zeros and, if it fits, the bit length.
					for (int i = 0; i < 16; i++) begin
						for (int j = 0; j < 4; j++) begin
							if (!pad_done_q && 6'(4*i + j) == fill_q)
								w_q[i][8*(3-j) +: 8] <= sha_pkg::PadByte;
							else if (pad_done_q || 6'(4*i + j) > fill_q)
								w_q[i][8*(3-j) +: 8] <= 8'h00;
						end
					end
					if (pad_last) begin
						w_q[14] <= bits_q[63:32];
						w_q[15] <= bits_q[31:0];
					end
					final_q    <= pad_last;
					pad_done_q <= ~pad_last;
					fill_q     <= '0;
					{a_q, b_q, c_q, d_q} <= {h_q[0], h_q[1], h_q[2], h_q[3]};
					{e_q, f_q, g_q, hh_q} <= {h_q[4], h_q[5], h_q[6], h_q[7]};
					round_q <= '0;
				end
				sha_pkg::ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					{b_q, c_q, d_q} <= {a_q, b_q, c_q};
					{f_q, g_q, hh_q} <= {e_q, f_q, g_q};
					a_q <= t1 + t2;
					e_q <= d_q + t1;
					round_q <= round_q + 1'b1;
				end
				sha_pkg::ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					widx_q <= '0;
					out_v_q <= final_q;
					out_w_q <= h_q[0] + a_q;
				end
				sha_pkg::ST_EMIT: begin
					if (out_ch.ready & out_v_q) begin
						if (widx_q == 3'd7) begin
							out_v_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitH[i];
							bits_q     <= '0;
							fill_q     <= '0;
							pad_done_q <= 1'b0;
							final_q    <= 1'b0;
						end else begin
							out_w_q <= h_q[widx_q + 3'd1];
						end
						widx_q <= widx_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Remember an end mark that arrived with the block-filling byte, so the
	// add step after that block goes on to pad.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) end_pend_q <= 1'b0;
		else if (take) end_pend_q <= blk_full & req.last;
		else if (state_q == sha_pkg::ST_ADD) end_pend_q <= 1'b0;
	end
endmodule

@@ hdl/sha256_message_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher, top level
// Front request queue plus back compression sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The in channel takes one request per cycle while in_ch.ready is high: a byte
// (byte_present), an end mark (end_of_message), or both. The out channel gives
// eight digest words, word_index 0 first, last_word on word 7.
// The back part takes bytes only while idle; a full block then runs the round
// steps and an add step in the single shared round unit. An end mark leads, for
// each padded block (one or two), through a pad step, the round steps and an add
// step, then the eight words go out one per cycle while the receiver is ready.
// A short request queue lets the sender keep going while a block compresses.
// Reset clears the queue, counts and loads the initial hash words.
// When the receiver stalls, the current word holds and the back part waits;
// the queue keeps filling until it is full and then lowers in_ch.ready.
// ----------------------------------------------------------------------------
module sha256_message_hasher #(
	parameter int QueueDepth = sha_pkg::QueueDepth
) (
	input logic        clk,
	input logic        arst_n,
	sha_in_if.sink     in_ch,
	sha_out_if.source  out_ch
);
	sha_pkg::req_t req;
	logic          req_valid, req_pop;

	sha_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .in_ch, .req, .req_valid, .req_pop
	);

	sha_back u_back (
		.clk, .arst_n, .req, .req_valid, .req_pop, .out_ch
	);
endmodule

@@ hdl/sha_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Checks output ordering seen on the top level's ports.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_assert.svh"
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_index,
	input logic        out_last,
	input logic [31:0] out_word
);
	// Last flag marks exactly word seven.
	`SHA_ASSERT_IMP(a_last, clk, arst_n, out_valid, out_last == (out_index == 3'd7), "last flag")
	// Words come in order.
	`SHA_ASSERT_NEXT(a_order, clk, arst_n, out_valid && out_ready && !out_last, out_valid && out_index == $past(out_index) + 3'd1, "word order")
	// A stalled word holds.
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word), "stall hold")
endmodule

bind sha256_message_hasher sha_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_index(out_ch.word_index), .out_last(out_ch.last_word), .out_word(out_ch.digest_word)
);
